### sv/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Default geometry
  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefKeyBits   = 32;
  localparam int unsigned DefValueBits = 32;

  // Fixed field widths
  localparam int unsigned ModeW = 2;
  localparam int unsigned StatW = 2;
  localparam int unsigned CntW  = 5;

  // Entries in the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Request kinds as decoded by the front
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_INVAL  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // Result status codes
  localparam logic [StatW-1:0] STAT_OK      = 2'd0;
  localparam logic [StatW-1:0] STAT_MISS    = 2'd1;
  localparam logic [StatW-1:0] STAT_CAP_ERR = 2'd2;

  // Back-end sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } back_state_e;

endpackage

### sv/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request beat is a lookup, insert, invalidate or no-op and yields one result
// beat with status, read value and occupancy. Requests enter a two-entry
// queue; the execution stage then captures the request and compares the key
// against all entries, then updates the table and recency ranks once the
// result slot is free, and takes no new request until that update is done.
// The capacity register may be written only while no request is in
// flight; it resets to 16 and values above DEPTH act as DEPTH.
module lru_key_value_cache_core #(
  parameter int unsigned DEPTH      = lkvc_pkg::DefDepth,
  parameter int unsigned KEY_BITS   = lkvc_pkg::DefKeyBits,
  parameter int unsigned VALUE_BITS = lkvc_pkg::DefValueBits,
  parameter int unsigned IN_W  =
    ((lkvc_pkg::ModeW + KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  parameter int unsigned OUT_W =
    ((lkvc_pkg::StatW + VALUE_BITS + lkvc_pkg::CntW + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lkvc_pkg::CntW-1:0] cfg_data_i,     // capacity
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_W-1:0]           s_axis_tdata,   // mode, key, value
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_W-1:0]          m_axis_tdata    // status, read_value, occupancy
);
  import lkvc_pkg::*;

  localparam int unsigned KeyLo = ModeW;
  localparam int unsigned ValLo = ModeW + KEY_BITS;
  localparam int unsigned RdLo  = StatW;
  localparam int unsigned OccLo = StatW + VALUE_BITS;
  localparam int unsigned OutUsed = StatW + VALUE_BITS + CntW;

  logic [CntW-1:0]       capacity_q;
  logic                  head_valid, head_ready;
  op_e                   head_op;
  logic [KEY_BITS-1:0]   head_key;
  logic [VALUE_BITS-1:0] head_value;
  logic [StatW-1:0]      res_status;
  logic [VALUE_BITS-1:0] res_value;
  logic [CntW-1:0]       res_count;

  // Capacity register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CntW'(16);
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  lkvc_front #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_mode_i    (s_axis_tdata[ModeW-1:0]),
    .in_key_i     (s_axis_tdata[KeyLo +: KEY_BITS]),
    .in_value_i   (s_axis_tdata[ValLo +: VALUE_BITS]),
    .head_valid_o (head_valid),
    .head_ready_i (head_ready),
    .head_op_o    (head_op),
    .head_key_o   (head_key),
    .head_value_o (head_value)
  );

  lkvc_back #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .capacity_i   (capacity_q),
    .head_valid_i (head_valid),
    .head_ready_o (head_ready),
    .head_op_i    (head_op),
    .head_key_i   (head_key),
    .head_value_i (head_value),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (res_status),
    .out_value_o  (res_value),
    .out_count_o  (res_count)
  );

  // Pack the result beat
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[StatW-1:0]         = res_status;
    m_axis_tdata[RdLo +: VALUE_BITS] = res_value;
    m_axis_tdata[OccLo +: CntW]     = res_count;
  end

`ifndef SYNTHESIS
  // Only a hit returns data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_status != STAT_OK) |-> (res_value == '0))
    else $error("read value nonzero on a non-hit result");

  // Occupancy never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (int'(res_count) <= int'(DEPTH)))
    else $error("occupancy above depth");

  // A capacity error only comes with zero capacity, which leaves the table unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) && (res_status == STAT_CAP_ERR) |-> (capacity_q == '0))
    else $error("capacity error with nonzero capacity");

  // Result padding stays zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata >> OutUsed) == '0))
    else $error("result padding bits set");
`endif

endmodule

### sv/lkvc_front.sv
// ----------------------------------------------------------------------------
// lkvc_front
// Accepts request beats, decodes the mode and holds them in a short queue.
// ----------------------------------------------------------------------------
module lkvc_front #(
  parameter int unsigned KEY_BITS   = lkvc_pkg::DefKeyBits,
  parameter int unsigned VALUE_BITS = lkvc_pkg::DefValueBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lkvc_pkg::ModeW-1:0] in_mode_i,
  input  logic [KEY_BITS-1:0]       in_key_i,
  input  logic [VALUE_BITS-1:0]     in_value_i,
  output logic                      head_valid_o,
  input  logic                      head_ready_i,
  output lkvc_pkg::op_e             head_op_o,
  output logic [KEY_BITS-1:0]       head_key_o,
  output logic [VALUE_BITS-1:0]     head_value_o
);
  import lkvc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  op_e                   op_q  [QueueDepth];
  logic [KEY_BITS-1:0]   key_q [QueueDepth];
  logic [VALUE_BITS-1:0] val_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0]      fill_q;
  logic                  push, pop;
  op_e                   op_dec;

  // Classify the request
  always_comb begin
    case (in_mode_i)
      2'd0:    op_dec = OP_LOOKUP;
      2'd1:    op_dec = OP_INSERT;
      2'd2:    op_dec = OP_INVAL;
      default: op_dec = OP_NOP;
    endcase
  end

  assign in_ready_o   = (fill_q != FillW'(QueueDepth));
  assign head_valid_o = (fill_q != '0);
  assign push         = in_valid_i && in_ready_o;
  assign pop          = head_valid_o && head_ready_i;
  assign head_op_o    = op_q[rd_ptr_q];
  assign head_key_o   = key_q[rd_ptr_q];
  assign head_value_o = val_q[rd_ptr_q];

  // Store payload at the write pointer
  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]  <= op_dec;
      key_q[wr_ptr_q] <= in_key_i;
      val_q[wr_ptr_q] <= in_value_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

### sv/lkvc_back.sv
// ----------------------------------------------------------------------------
// lkvc_back
// Executes requests against the entry table and keeps the recency ranks.
// ----------------------------------------------------------------------------
module lkvc_back #(
  parameter int unsigned DEPTH      = lkvc_pkg::DefDepth,
  parameter int unsigned KEY_BITS   = lkvc_pkg::DefKeyBits,
  parameter int unsigned VALUE_BITS = lkvc_pkg::DefValueBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lkvc_pkg::CntW-1:0]  capacity_i,
  input  logic                       head_valid_i,
  output logic                       head_ready_o,
  input  lkvc_pkg::op_e              head_op_i,
  input  logic [KEY_BITS-1:0]        head_key_i,
  input  logic [VALUE_BITS-1:0]      head_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [lkvc_pkg::StatW-1:0] out_status_o,
  output logic [VALUE_BITS-1:0]      out_value_o,
  output logic [lkvc_pkg::CntW-1:0]  out_count_o
);
  import lkvc_pkg::*;

  localparam int unsigned IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RankW = IdxW;

  // Entry table
  logic [KEY_BITS-1:0]   key_q  [DEPTH];
  logic [VALUE_BITS-1:0] val_q  [DEPTH];
  logic [RankW-1:0]      rank_q [DEPTH];
  logic [RankW-1:0]      rank_d [DEPTH];
  logic [DEPTH-1:0]      valid_q, valid_d;
  logic [CntW-1:0]       count_q, count_d;

  // Captured request
  back_state_e           state_q, state_d;
  op_e                   op_q;
  logic [KEY_BITS-1:0]   req_key_q;
  logic [VALUE_BITS-1:0] req_val_q;
  logic [DEPTH-1:0]      hit_q;

  // Result register
  logic                  out_valid_q;
  logic [StatW-1:0]      out_status_q;
  logic [VALUE_BITS-1:0] out_value_q;
  logic [CntW-1:0]       out_count_q;

  logic                  take, fire;
  logic                  hit_any;
  logic [IdxW-1:0]       slot_idx, free_idx;
  logic [DEPTH-1:0]      victim_oh, valid_after;
  logic                  free_found, victim_found;
  logic [CntW-1:0]       cap_eff, count_mid;
  logic                  evict;
  logic [StatW-1:0]      status;
  logic [VALUE_BITS-1:0] rd_value;
  logic                  dec_en;
  logic [RankW-1:0]      dec_thr;
  logic [DEPTH-1:0]      valid_clr;
  logic                  set_en;
  logic [IdxW-1:0]       set_idx;
  logic [RankW-1:0]      set_rank;
  logic                  wr_key_en, wr_val_en;

  assign head_ready_o = (state_q == ST_IDLE);
  assign take         = head_valid_i && head_ready_o;

  // Sequence: capture and compare, then execute when the result slot is free
  always_comb begin
    state_d = state_q;
    fire    = 1'b0;
    case (state_q)
      ST_IDLE: if (take) state_d = ST_EXEC;
      ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          fire    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the request and the key match vector
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q      <= head_op_i;
      req_key_q <= head_key_i;
      req_val_q <= head_value_i;
      for (int i = 0; i < DEPTH; i++) begin
        hit_q[i] <= valid_q[i] && (key_q[i] == head_key_i);
      end
    end
  end

  // Encode the hit and the oldest entry
  always_comb begin
    slot_idx     = '0;
    victim_oh    = '0;
    victim_found = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_q[i]) slot_idx = slot_idx | IdxW'(i);
      if (!victim_found && valid_q[i] && rank_q[i] == '0) begin
        victim_found = 1'b1;
        victim_oh[i] = 1'b1;
      end
    end
  end

  assign hit_any     = |hit_q;
  assign cap_eff     = (int'(capacity_i) > int'(DEPTH)) ? CntW'(DEPTH) : capacity_i;
  assign evict       = (count_q >= cap_eff);
  assign valid_after = evict ? (valid_q & ~victim_oh) : valid_q;
  assign count_mid   = evict ? (count_q - 1'b1) : count_q;

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!free_found && !valid_after[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  // Decide the table update for the captured request
  always_comb begin
    status    = STAT_OK;
    rd_value  = '0;
    dec_en    = 1'b0;
    dec_thr   = rank_q[slot_idx];
    valid_clr = '0;
    set_en    = 1'b0;
    set_idx   = slot_idx;
    set_rank  = RankW'(count_q - 1'b1);
    wr_key_en = 1'b0;
    wr_val_en = 1'b0;
    valid_d   = valid_q;
    count_d   = count_q;
    case (op_q)
      OP_LOOKUP: begin
        if (hit_any) begin
          rd_value = val_q[slot_idx];
          dec_en   = 1'b1;
          set_en   = 1'b1;
        end else begin
          status = STAT_MISS;
        end
      end
      OP_INSERT: begin
        if (cap_eff == '0) begin
          status = STAT_CAP_ERR;
        end else if (hit_any) begin
          wr_val_en = 1'b1;
          dec_en    = 1'b1;
          set_en    = 1'b1;
        end else begin
          // Drop the oldest entry when full, then append as most recent
          dec_en    = evict;
          dec_thr   = '0;
          valid_clr = evict ? victim_oh : '0;
          set_en    = 1'b1;
          set_idx   = free_idx;
          set_rank  = RankW'(count_mid);
          wr_key_en = 1'b1;
          wr_val_en = 1'b1;
          valid_d   = valid_after;
          valid_d[free_idx] = 1'b1;
          count_d   = count_mid + 1'b1;
        end
      end
      OP_INVAL: begin
        if (hit_any) begin
          dec_en    = 1'b1;
          valid_clr = hit_q;
          valid_d   = valid_q & ~hit_q;
          count_d   = count_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Close the rank gap left by the moved or dropped entry
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      rank_d[j] = rank_q[j];
      if (dec_en && valid_q[j] && !valid_clr[j] && rank_q[j] > dec_thr) begin
        rank_d[j] = rank_q[j] - 1'b1;
      end
    end
    if (set_en) rank_d[set_idx] = set_rank;
  end

  // Table payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int j = 0; j < DEPTH; j++) rank_q[j] <= rank_d[j];
      if (wr_key_en) key_q[set_idx] <= req_key_q;
      if (wr_val_en) val_q[set_idx] <= req_val_q;
    end
  end

  // Table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (fire) begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= status;
      out_value_q  <= rd_value;
      out_count_q  <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_count_o  = out_count_q;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the LRU key-value cache core.
// ----------------------------------------------------------------------------
// A directed table covers reset state, field extremes, every mode, capacity
// zero, capacity above DEPTH, eviction and capacity lowered below occupancy.
// Random traffic then runs on a small key pool so that hits, updates and
// evictions are frequent. Every result beat is checked against an LRU model
// kept inside the testbench. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import lkvc_pkg::*;

  localparam int Depth = 16;
  localparam int InW   = 72;
  localparam int OutW  = 40;
  localparam int MaxCycles = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] rd;
    logic [4:0]  occ;
  } cache_res_t;

  typedef struct {
    op_e         mode;
    logic [31:0] key;
    logic [31:0] value;
    logic        chk;     // typed-in expectation present
    cache_res_t  res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [4:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;   // mode, key, value
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;       // status, read_value, occupancy

  lru_key_value_cache_core DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // LRU model state
  logic [31:0] lru_key [Depth];
  logic [31:0] lru_val [Depth];
  logic        lru_vld [Depth];
  int unsigned lru_rank[Depth];
  int unsigned lru_cnt;
  int unsigned lru_cap;

  cache_res_t pending_res[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;       // no idling in the last part

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h (t=%0t)", what, got, exp, $time);
    errors++;
  endtask

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < Depth; i++)
      if (lru_vld[i] && lru_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void promote(int s);
    int unsigned r;
    r = lru_rank[s];
    for (int j = 0; j < Depth; j++)
      if (lru_vld[j] && lru_rank[j] > r) lru_rank[j]--;
    lru_rank[s] = lru_cnt - 1;
  endfunction

  function automatic void drop(int s);
    int unsigned r;
    r = lru_rank[s];
    lru_vld[s] = 1'b0;
    for (int j = 0; j < Depth; j++)
      if (lru_vld[j] && lru_rank[j] > r) lru_rank[j]--;
    lru_cnt--;
  endfunction

  function automatic cache_res_t predict_access(op_e m, logic [31:0] k, logic [31:0] v);
    cache_res_t r;
    int s;
    int unsigned cap;
    bit done;
    r = '0;
    s = find_slot(k);
    cap = (lru_cap > Depth) ? Depth : lru_cap;
    done = 1'b0;
    case (m)
      OP_LOOKUP: begin
        if (s >= 0) begin
          r.rd = lru_val[s];
          promote(s);
        end else r.status = STAT_MISS;
      end
      OP_INSERT: begin
        if (cap == 0) r.status = STAT_CAP_ERR;
        else if (s >= 0) begin
          lru_val[s] = v;
          promote(s);
        end else begin
          if (lru_cnt >= cap)
            for (int j = 0; j < Depth && !done; j++)
              if (lru_vld[j] && lru_rank[j] == 0) begin
                drop(j);
                done = 1'b1;
              end
          done = 1'b0;
          for (int j = 0; j < Depth && !done; j++)
            if (!lru_vld[j]) begin
              lru_vld[j] = 1'b1;
              lru_key[j] = k;
              lru_val[j] = v;
              lru_rank[j] = lru_cnt;
              lru_cnt++;
              done = 1'b1;
            end
        end
      end
      OP_INVAL: if (s >= 0) drop(s);
      default: ;
    endcase
    r.occ = lru_cnt[4:0];
    return r;
  endfunction

  // Send one request beat and queue its expected result
  task automatic send_req(op_e m, logic [31:0] k, logic [31:0] v,
                          bit chk, cache_res_t typed);
    cache_res_t r;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {{(InW - 66){1'b0}}, v, k, m};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_access(m, k, v);
    if (chk) begin
      if (r.status != typed.status)
        report("table row status", 32'(r.status), 32'(typed.status));
      if (r.rd != typed.rd) report("table row read_value", r.rd, typed.rd);
      if (r.occ != typed.occ) report("table row occupancy", 32'(r.occ), 32'(typed.occ));
    end
    pending_res.insert(pending_res.size(), r);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_capacity(int unsigned c);
    drain();
    cfg_data_i <= c[4:0];
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    lru_cap = c;
  endtask

  // Result checking and receiver stalls
  always @(posedge clk_i) begin
    cache_res_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{status: m_axis_tdata[1:0], rd: m_axis_tdata[33:2],
              occ: m_axis_tdata[38:34]};
      if (pending_res.size() == 0) report("unexpected beat", got.rd, 0);
      else begin
        exp = pending_res.pop_front();
        if (got.status !== exp.status)
          report("status", 32'(got.status), 32'(exp.status));
        if (got.rd !== exp.rd) report("read_value", got.rd, exp.rd);
        if (got.occ !== exp.occ) report("occupancy", 32'(got.occ), 32'(exp.occ));
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 13) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic dir_row_t row(op_e m, logic [31:0] k, logic [31:0] v,
                                   bit c = 0, logic [1:0] st = 0,
                                   logic [31:0] rd = 0, logic [4:0] oc = 0);
    dir_row_t d;
    d.mode = m; d.key = k; d.value = v; d.chk = c;
    d.res = '{status: st, rd: rd, occ: oc};
    return d;
  endfunction

  dir_row_t dir_tab[$];

  // Append one row to the directed table
  function automatic void add_row(dir_row_t d);
    dir_tab.insert(dir_tab.size(), d);
  endfunction

  initial begin
    logic [31:0] keys[8];
    int unsigned caps[6];
    op_e m;
    int pick;
    for (int i = 0; i < Depth; i++) begin
      lru_vld[i] = 1'b0;
      lru_rank[i] = 0;
      lru_key[i] = '0;
      lru_val[i] = '0;
    end
    lru_cnt = 0;
    lru_cap = 16;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at reset capacity
    add_row(row(OP_LOOKUP, 32'h0, 32'h0, 1, STAT_MISS, 0, 0));
    add_row(row(OP_INVAL, 32'hFFFF_FFFF, 32'h0, 1, STAT_OK, 0, 0));
    add_row(row(OP_NOP, 32'h1234, 32'hFFFF_FFFF, 1, STAT_OK, 0, 0));
    add_row(row(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STAT_OK, 0, 1));
    add_row(row(OP_INSERT, 32'h0, 32'h0, 1, STAT_OK, 0, 2));
    add_row(row(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1, STAT_OK, 32'hFFFF_FFFF, 2));
    add_row(row(OP_INSERT, 32'h0, 32'hA5A5_5A5A));
    add_row(row(OP_LOOKUP, 32'h0, 32'h0));
    add_row(row(OP_INVAL, 32'h0, 32'h0, 1, STAT_OK, 0, 1));
    for (int i = 0; i < 16; i++)
      add_row(row(OP_INSERT, 32'h100 + i, 32'h5555_0000 + i));
    foreach (dir_tab[i])
      send_req(dir_tab[i].mode, dir_tab[i].key, dir_tab[i].value,
               dir_tab[i].chk, dir_tab[i].res);

    // Lower capacity below occupancy, then zero, then above DEPTH
    write_capacity(3);
    send_req(OP_INSERT, 32'h777, 32'h1, 0, '0);
    send_req(OP_LOOKUP, 32'h101, 32'h0, 0, '0);
    write_capacity(0);
    send_req(OP_INSERT, 32'h999, 32'h2, 1, '{status: STAT_CAP_ERR, rd: 0, occ: 16});
    send_req(OP_LOOKUP, 32'h777, 32'h0, 0, '0);
    send_req(OP_INVAL, 32'h777, 32'h0, 0, '0);
    write_capacity(31);
    send_req(OP_INSERT, 32'h888, 32'h3, 0, '0);

    // Random phases across capacity settings
    caps = '{1, 16, 5, 0, 31, 8};
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(caps[ph]);
      for (int i = 0; i < 8; i++) keys[i] = $urandom();
      keys[0] = '0; keys[1] = '1;
      if (ph == 5) quiet = 1'b1;
      for (int n = 0; n < 170; n++) begin
        pick = $urandom_range(0, 9);
        m = pick < 4 ? OP_INSERT : pick < 7 ? OP_LOOKUP : pick < 9 ? OP_INVAL : OP_NOP;
        send_req(m, ($urandom_range(0, 9) == 0) ? $urandom() : keys[$urandom_range(0, 7)],
                 $urandom(), 0, '0);
        if (ph == 2 && n == 80) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
sv/lkvc_pkg.sv
sv/lkvc_front.sv
sv/lkvc_back.sv
sv/lru_key_value_cache_core.sv
dv/tb_top.sv
